// ===== hdl/tse_pkg.sv =====
// Shared constants, codes and types of the topological sort engine.
// No dependencies; every other file of the engine but tse_ram uses this package.
package tse_pkg;

   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;

   localparam int NODE_W   = 6;
   localparam int CFG_W    = 7;
   localparam int STATUS_W = 2;

   localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W   = $clog2(MAX_NODES + 1);
   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
   localparam int DEG_W   = ECNT_W;

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = CFG_W'(64);

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
   } req_item_type;

   typedef struct packed {
      logic                valid;
      logic [NODE_W-1:0]   node;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_push_type;

endpackage

// ===== hdl/tse_if.sv =====
// Channel interfaces of the topological sort engine: request, response, csr write.
// Depends on tse_pkg for field widths.
interface tse_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [tse_pkg::NODE_W-1:0] from_node;
   logic [tse_pkg::NODE_W-1:0] to_node;
   modport source (output valid, output cmd, output from_node, output to_node, input ready);
   modport sink (input valid, input cmd, input from_node, input to_node, output ready);
endinterface

interface tse_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tse_pkg::NODE_W-1:0]   node;
   logic [tse_pkg::STATUS_W-1:0] status;
   logic                         last;
   modport source (output valid, output node, output status, output last, input ready);
   modport sink (input valid, input node, input status, input last, output ready);
endinterface

interface tse_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tse_pkg::CFG_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/tse_out.sv =====
// Result output register: holds one result until the response transfer.
// Depends on tse_pkg and tse_if.
module tse_out (
   input  logic                  clock,
   input  logic                  reset,
   input  tse_pkg::rsp_push_type push,
   output logic                  out_free,
   tse_rsp_if.source             rsp_bus
);

   logic                         vld_ff, vld_in;
   logic [tse_pkg::NODE_W-1:0]   node_ff;
   logic [tse_pkg::STATUS_W-1:0] status_ff;
   logic                         last_ff;

   always_comb begin
      out_free = !vld_ff || rsp_bus.ready;
      if (push.valid) begin
         vld_in = 1'b1;
      end else if (rsp_bus.ready) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         node_ff   <= push.node;
         status_ff <= push.status;
         last_ff   <= push.last;
      end
   end

   assign rsp_bus.valid  = vld_ff;
   assign rsp_bus.node   = node_ff;
   assign rsp_bus.status = status_ff;
   assign rsp_bus.last   = last_ff;

endmodule

// ===== hdl/tse_seq.sv =====
// Sequencer of the sort: edge store, in-degree store, order queue and the Kahn walk.
// Depends on tse_pkg and tse_ram.
module tse_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [tse_pkg::CFG_W-1:0] n_eff,
   input  logic                      req_valid,
   input  tse_pkg::req_item_type     req_item,
   output logic                      req_ready,
   input  logic                      out_free,
   output tse_pkg::rsp_push_type     push
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LDWR  = 4'd1;
   localparam logic [3:0] S_INIT  = 4'd2;
   localparam logic [3:0] S_DEQ   = 4'd3;
   localparam logic [3:0] S_CUR   = 4'd4;
   localparam logic [3:0] S_ERD   = 4'd5;
   localparam logic [3:0] S_ECHK  = 4'd6;
   localparam logic [3:0] S_DUPD  = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_ERES  = 4'd9;
   localparam logic [3:0] S_EMRD  = 4'd10;
   localparam logic [3:0] S_EMPUT = 4'd11;

   localparam int NW  = tse_pkg::NODE_W;
   localparam int NAW = tse_pkg::NODE_AW;
   localparam int CW  = tse_pkg::CNT_W;
   localparam int EAW = tse_pkg::EDGE_AW;
   localparam int ECW = tse_pkg::ECNT_W;
   localparam int DW  = tse_pkg::DEG_W;
   localparam int FW  = tse_pkg::CFG_W;

   logic [3:0]                   state_ff, state_in;
   logic [ECW-1:0]               estored_ff, estored_in;
   logic [NW-1:0]                max_ep_ff, max_ep_in;
   logic                         err_ff, err_in;
   logic [tse_pkg::MAX_NODES-1:0] vld_ff, vld_in;
   logic [CW-1:0]                head_ff, head_in;
   logic [CW-1:0]                tail_ff, tail_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [ECW-1:0]               e_ff, e_in;
   logic [NW-1:0]                cur_ff, cur_in;
   logic [NW-1:0]                tgt_ff, tgt_in;
   logic [tse_pkg::STATUS_W-1:0] code_ff, code_in;

   logic               e_wr_en;
   logic [EAW-1:0]     e_wr_addr, e_rd_addr;
   logic [2*NW-1:0]    e_wr_data, e_rd_data;
   logic               d_wr_en;
   logic [NAW-1:0]     d_wr_addr, d_rd_addr;
   logic [DW-1:0]      d_wr_data, d_rd_data;
   logic               q_wr_en;
   logic [NAW-1:0]     q_wr_addr, q_rd_addr;
   logic [NW-1:0]      q_wr_data, q_rd_data;

   logic               accept;
   logic               bad_edge;
   logic               run_err;
   logic               e_last;
   logic               q_room;
   logic               clear;
   logic [DW-1:0]      deg_cur;
   logic [NW-1:0]      e_src, e_dst;
   logic [NW-1:0]      ep_hi;

   always_comb begin
      e_src    = e_rd_data[2*NW-1:NW];
      e_dst    = e_rd_data[NW-1:0];
      accept   = req_valid && req_ready;
      bad_edge = (FW'(req_item.from_node) >= n_eff) || (FW'(req_item.to_node) >= n_eff) ||
                 (estored_ff == ECW'(tse_pkg::MAX_EDGES));
      run_err  = err_ff || ((estored_ff != '0) && (FW'(max_ep_ff) >= n_eff));
      e_last   = (e_ff + ECW'(1)) == estored_ff;
      q_room   = tail_ff < CW'(tse_pkg::MAX_NODES);
      deg_cur  = vld_ff[tgt_ff[NAW-1:0]] ? d_rd_data : '0;
      ep_hi    = (req_item.from_node > req_item.to_node) ? req_item.from_node
                                                         : req_item.to_node;

      state_in   = state_ff;
      estored_in = estored_ff;
      max_ep_in  = max_ep_ff;
      err_in     = err_ff;
      vld_in     = vld_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      idx_in     = idx_ff;
      e_in       = e_ff;
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      code_in    = code_ff;
      clear      = 1'b0;

      req_ready = (state_ff == S_IDLE);
      push      = '0;

      e_wr_en   = 1'b0;
      e_wr_addr = estored_ff[EAW-1:0];
      e_wr_data = {req_item.from_node, req_item.to_node};
      e_rd_addr = e_ff[EAW-1:0];
      d_wr_en   = 1'b0;
      d_wr_addr = tgt_ff[NAW-1:0];
      d_wr_data = deg_cur + DW'(1);
      d_rd_addr = tgt_ff[NAW-1:0];
      q_wr_en   = 1'b0;
      q_wr_addr = tail_ff[NAW-1:0];
      q_wr_data = NW'(idx_ff);
      q_rd_addr = idx_ff[NAW-1:0];

      case (state_ff)
         S_IDLE: begin
            d_rd_addr = req_item.to_node[NAW-1:0];
            if (accept) begin
               if (req_item.cmd == tse_pkg::CMD_EDGE) begin
                  if (bad_edge) begin
                     err_in = 1'b1;
                  end else begin
                     e_wr_en    = 1'b1;
                     estored_in = estored_ff + ECW'(1);
                     if ((estored_ff == '0) || (ep_hi > max_ep_ff)) begin
                        max_ep_in = ep_hi;
                     end
                     tgt_in   = req_item.to_node;
                     state_in = S_LDWR;
                  end
               end else if (run_err) begin
                  code_in  = tse_pkg::STATUS_DROP;
                  state_in = S_ERES;
               end else begin
                  idx_in   = '0;
                  head_in  = '0;
                  tail_in  = '0;
                  state_in = S_INIT;
               end
            end
         end
         S_LDWR: begin
            d_wr_en                   = 1'b1;
            vld_in[tgt_ff[NAW-1:0]]   = 1'b1;
            state_in                  = S_IDLE;
         end
         S_INIT: begin
            if (!vld_ff[idx_ff[NAW-1:0]] && q_room) begin
               q_wr_en = 1'b1;
               tail_in = tail_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
            if ((FW'(idx_ff) + FW'(1)) == n_eff) begin
               state_in = S_DEQ;
            end
         end
         S_DEQ: begin
            q_rd_addr = head_ff[NAW-1:0];
            if ((head_ff < tail_ff) && (head_ff < CW'(tse_pkg::MAX_NODES))) begin
               head_in  = head_ff + CW'(1);
               state_in = S_CUR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CUR: begin
            cur_in = q_rd_data;
            e_in   = '0;
            if (estored_ff == '0) begin
               state_in = S_DEQ;
            end else begin
               state_in = S_ERD;
            end
         end
         S_ERD: begin
            state_in = S_ECHK;
         end
         S_ECHK: begin
            d_rd_addr = e_dst[NAW-1:0];
            if (e_src == cur_ff) begin
               tgt_in   = e_dst;
               state_in = S_DUPD;
            end else if (e_last) begin
               state_in = S_DEQ;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = S_ERD;
            end
         end
         S_DUPD: begin
            if (deg_cur != '0) begin
               d_wr_en                 = 1'b1;
               d_wr_data               = deg_cur - DW'(1);
               vld_in[tgt_ff[NAW-1:0]] = 1'b1;
               if ((deg_cur == DW'(1)) && q_room) begin
                  q_wr_en   = 1'b1;
                  q_wr_data = tgt_ff;
                  tail_in   = tail_ff + CW'(1);
               end
            end
            if (e_last) begin
               state_in = S_DEQ;
            end else begin
               e_in     = e_ff + ECW'(1);
               state_in = S_ERD;
            end
         end
         S_FIN: begin
            if (FW'(tail_ff) != n_eff) begin
               code_in  = tse_pkg::STATUS_CYCLE;
               state_in = S_ERES;
            end else begin
               idx_in   = '0;
               state_in = S_EMRD;
            end
         end
         S_ERES: begin
            if (out_free) begin
               push.valid  = 1'b1;
               push.node   = '0;
               push.status = code_ff;
               push.last   = 1'b1;
               clear       = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EMRD: begin
            state_in = S_EMPUT;
         end
         S_EMPUT: begin
            if (out_free) begin
               push.valid  = 1'b1;
               push.node   = q_rd_data;
               push.status = tse_pkg::STATUS_OK;
               push.last   = (FW'(idx_ff) + FW'(1)) == n_eff;
               if (push.last) begin
                  clear    = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_EMRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear) begin
         estored_in = '0;
         max_ep_in  = '0;
         err_in     = 1'b0;
         vld_in     = '0;
         head_in    = '0;
         tail_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         estored_ff <= '0;
         max_ep_ff  <= '0;
         err_ff     <= 1'b0;
         vld_ff     <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         estored_ff <= estored_in;
         max_ep_ff  <= max_ep_in;
         err_ff     <= err_in;
         vld_ff     <= vld_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      e_ff    <= e_in;
      cur_ff  <= cur_in;
      tgt_ff  <= tgt_in;
      code_ff <= code_in;
   end

   tse_ram #(.WIDTH(2 * NW), .DEPTH(tse_pkg::MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   tse_ram #(.WIDTH(DW), .DEPTH(tse_pkg::MAX_NODES)) u_deg_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_addr (d_rd_addr),
      .rd_data (d_rd_data)
   );

   tse_ram #(.WIDTH(NW), .DEPTH(tse_pkg::MAX_NODES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_free)
      else $error("result pushed while output register is busy");

   a_head_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed queue tail");

   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.last) |=> (estored_ff == '0) && (vld_ff == '0) && !err_ff)
      else $error("stores not cleared after the final result of a run");

   a_edge_count_step: assert property (@(posedge clock) disable iff (reset)
      (estored_ff != $past(estored_ff)) |->
         ((estored_ff == $past(estored_ff) + ECW'(1)) || (estored_ff == '0)))
      else $error("edge count changed by more than one");

endmodule

// ===== hdl/topological_sort_engine_top.sv =====
// Top level of the topological sort engine: node_count register, sequencer, output stage.
// Depends on tse_pkg, tse_if, tse_seq and tse_out.
//
// An edge transfer (cmd 0) writes the edge to the edge store, and the target's
// in-degree goes through a read-modify-write of the in-degree RAM; req ready stays
// low until that write is done. A run transfer (cmd 1) holds req ready low while
// the sequencer walks the graph: it queues the zero in-degree nodes, then for every
// dequeued node reads each stored edge through the single edge RAM read port and
// updates the target of every edge leaving that node, then emits the sorted nodes,
// waiting while rsp ready stalls. A run that finds a dropped edge answers with the
// drop status. Results wait in an output register, so the next request is taken
// while the final result of a run is still pending. The csr channel is always ready
// and should be written only while the engine is idle.
module topological_sort_engine_top (
   input  logic      clock,
   input  logic      reset,
   tse_req_if.sink   req_bus,
   tse_rsp_if.source rsp_bus,
   tse_csr_if.sink   csr_bus
);

   logic [tse_pkg::CFG_W-1:0] node_count_ff, node_count_in;
   logic [tse_pkg::CFG_W-1:0] n_eff;
   tse_pkg::req_item_type     req_item;
   tse_pkg::rsp_push_type     push;
   logic                      out_free;
   logic                      req_ready;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_bus.valid) begin
         node_count_in = csr_bus.data;
      end
      if (node_count_ff == '0) begin
         n_eff = tse_pkg::CFG_W'(1);
      end else if (node_count_ff > tse_pkg::CFG_W'(tse_pkg::MAX_NODES)) begin
         n_eff = tse_pkg::CFG_W'(tse_pkg::MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
      req_item.cmd       = req_bus.cmd;
      req_item.from_node = req_bus.from_node;
      req_item.to_node   = req_bus.to_node;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= tse_pkg::NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   tse_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff),
      .req_valid (req_bus.valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .out_free  (out_free),
      .push      (push)
   );

   tse_out u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
